### rtl/core/gbr_pkg.sv
package gbr_pkg;

	localparam int KERNEL_TAPS = 15;
	localparam int MAX_WIDTH = 1024;
	localparam int MAX_HEIGHT = 1024;
	localparam int HALF = KERNEL_TAPS / 2;
	localparam int SPAN = 2 * HALF + 1;

	localparam int OP_W = 2;
	localparam int KSEL_W = 2;
	localparam int TAP_FIELD_W = 5;
	localparam int COEF_W = 16;
	localparam int PIX_W = 8;
	localparam int OUT_W = 52;
	localparam int DIM_W = 11;
	localparam int CFG_IDX_W = 2;

	localparam int TAP_W = $clog2(KERNEL_TAPS);
	localparam int COL_W = $clog2(MAX_WIDTH);
	localparam int ROW_W = $clog2(MAX_HEIGHT);
	localparam int SLOT_W = $clog2(SPAN);
	localparam int ADDR_W = SLOT_W + COL_W;
	localparam int MEM_DEPTH = SPAN * MAX_WIDTH;
	localparam int POS_W = $clog2(MAX_WIDTH * MAX_HEIGHT + HALF * MAX_WIDTH + HALF + 2);
	localparam int HPROD_W = COEF_W + PIX_W + 1;
	localparam int STORE_W = 30;
	localparam int VPROD_W = COEF_W + STORE_W;

	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = QPTR_W + 1;

	localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;

	typedef enum logic [OP_W-1:0] {
		OP_LOAD = 2'd0,
		OP_PIXEL = 2'd1,
		OP_FLUSH = 2'd2,
		OP_IGNORE = 2'd3
	} op_t;

	typedef enum logic [KSEL_W-1:0] {
		KS_COS_H = 2'd0,
		KS_COS_V = 2'd1,
		KS_SIN_H = 2'd2,
		KS_SIN_V = 2'd3
	} ksel_t;

	typedef enum logic [1:0] {
		WK_LOAD,
		WK_PIXEL,
		WK_FLUSH
	} work_kind_t;

	typedef struct packed {
		work_kind_t kind;
		ksel_t ksel;
		logic [TAP_W-1:0] tap;
		logic signed [COEF_W-1:0] coef;
		logic [PIX_W-1:0] pix;
	} work_t;

	typedef struct packed {
		logic valid;
		work_t item;
	} q_head_t;

	typedef struct packed {
		logic emit;
		logic emit_last;
		logic at_start;
	} back_stat_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_HORIZ,
		ST_HDRAIN,
		ST_HWRITE,
		ST_VERT,
		ST_VDRAIN,
		ST_EMIT
	} back_state_t;

endpackage

### rtl/core/gbr_ifs.sv
interface gbr_in_if import gbr_pkg::*; ();
	logic valid;
	logic ready;
	logic [OP_W-1:0] operation;
	logic [KSEL_W-1:0] kernel_select;
	logic [TAP_FIELD_W-1:0] tap_index;
	logic signed [COEF_W-1:0] coef_value;
	logic [PIX_W-1:0] pixel_value;

	modport source (output valid, operation, kernel_select, tap_index, coef_value,
		pixel_value, input ready);
	modport sink (input valid, operation, kernel_select, tap_index, coef_value,
		pixel_value, output ready);
endinterface

interface gbr_out_if import gbr_pkg::*; ();
	logic valid;
	logic ready;
	logic signed [OUT_W-1:0] filter_out;
	logic frame_end;

	modport source (output valid, filter_out, frame_end, input ready);
	modport sink (input valid, filter_out, frame_end, output ready);
endinterface

interface gbr_cfg_if import gbr_pkg::*; ();
	logic valid;
	logic ready;
	logic [CFG_IDX_W-1:0] index;
	logic [DIM_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

### rtl/core/gbr_front.sv
module gbr_front import gbr_pkg::*; (
	input logic clk,
	input logic arst_n,
	gbr_in_if.sink item,
	output q_head_t head,
	input logic pop
);

	work_t fifo_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	work_t entry;
	logic keep;
	logic push;

	always_comb begin
		entry.ksel = ksel_t'(item.kernel_select);
		entry.tap = item.tap_index[TAP_W-1:0];
		entry.coef = item.coef_value;
		entry.pix = item.pixel_value;
		entry.kind = WK_PIXEL;
		keep = 1'b0;
		case (op_t'(item.operation))
			OP_LOAD: begin
				entry.kind = WK_LOAD;
				// taps beyond the kernel length are dropped here
				keep = 32'(item.tap_index) < 32'(KERNEL_TAPS);
			end
			OP_PIXEL: begin
				entry.kind = WK_PIXEL;
				keep = 1'b1;
			end
			OP_FLUSH: begin
				entry.kind = WK_FLUSH;
				keep = 1'b1;
			end
			default: keep = 1'b0;
		endcase
	end

	assign item.ready = count_q != QCNT_W'(QDEPTH);
	assign push = item.valid && item.ready && keep;
	assign head.valid = count_q != '0;
	assign head.item = fifo_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop) rd_ptr_q <= rd_ptr_q + 1'b1;
			count_q <= count_q + QCNT_W'(push) - QCNT_W'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) fifo_q[wr_ptr_q] <= entry;
	end

endmodule

### rtl/core/gbr_back.sv
module gbr_back import gbr_pkg::*; (
	input logic clk,
	input logic arst_n,
	input q_head_t head,
	output logic pop,
	gbr_cfg_if.sink cfg,
	gbr_out_if.source result,
	output back_stat_t stat
);

	localparam int HC_W = COL_W + 2;
	localparam int VR_W = ROW_W + 2;

	back_state_t state_q, state_d;

	logic [DIM_W-1:0] frame_width_q, frame_height_q;
	logic [COL_W:0] w_c;
	logic [ROW_W:0] h_c;
	logic [POS_W-1:0] total_q, lag_q, idx_q;
	logic settle_q;

	logic [PIX_W-1:0] win_q [KERNEL_TAPS];
	logic signed [COEF_W-1:0] tap_a_q [KERNEL_TAPS];
	logic signed [COEF_W-1:0] tap_b_q [KERNEL_TAPS];
	logic signed [COEF_W-1:0] tap_c_q [KERNEL_TAPS];
	logic signed [COEF_W-1:0] tap_d_q [KERNEL_TAPS];

	logic signed [STORE_W-1:0] cos_mem [MEM_DEPTH];
	logic signed [STORE_W-1:0] sin_mem [MEM_DEPTH];

	logic [COL_W-1:0] hcol_q, vcol_q;
	logic [SLOT_W-1:0] hslot_q, vslot_q, rslot_q;
	logic [ROW_W-1:0] vrow_q;
	logic [TAP_W-1:0] kcnt_q;
	logic v_go_q, last_q;

	logic signed [HPROD_W-1:0] hprod_a_s1, hprod_c_s1;
	logic hv_s1;
	logic signed [STORE_W-1:0] hacc_a_q, hacc_c_q;

	logic signed [STORE_W-1:0] cos_rd_s1, sin_rd_s1;
	logic signed [COEF_W-1:0] tb_s1, td_s1;
	logic vv_s1;
	logic signed [VPROD_W-1:0] pb_s2, pd_s2;
	logic vv_s2;
	logic signed [OUT_W-1:0] vacc_q;

	logic res_valid_q;
	logic signed [OUT_W-1:0] res_data_q;
	logic res_last_q;

	logic cfg_wr, idle_ok, in_frame, step, h_go, v_go, last_c;
	logic k_last, res_free, emit, restart;
	logic signed [HC_W-1:0] hc, w_s;
	logic signed [VR_W-1:0] vr, h_s;
	logic h_in, v_in;
	logic [SLOT_W:0] slot_sum;
	logic [SLOT_W-1:0] rslot_start;
	logic [POS_W-1:0] q_pos;

	// clamp the frame registers into the supported range
	always_comb begin
		if (frame_width_q == '0) w_c = (COL_W + 1)'(1);
		else if (32'(frame_width_q) > 32'(MAX_WIDTH)) w_c = (COL_W + 1)'(MAX_WIDTH);
		else w_c = (COL_W + 1)'(frame_width_q);
		if (frame_height_q == '0) h_c = (ROW_W + 1)'(1);
		else if (32'(frame_height_q) > 32'(MAX_HEIGHT)) h_c = (ROW_W + 1)'(MAX_HEIGHT);
		else h_c = (ROW_W + 1)'(frame_height_q);
	end

	assign cfg.ready = 1'b1;
	assign cfg_wr = cfg.valid && cfg.ready;

	assign idle_ok = (state_q == ST_IDLE) && head.valid && !settle_q;
	assign in_frame = idx_q < total_q;
	assign step = (head.item.kind == WK_PIXEL) || ((head.item.kind == WK_FLUSH) && !in_frame);
	assign h_go = (idx_q >= POS_W'(HALF)) && ((idx_q - POS_W'(HALF)) < total_q);
	assign q_pos = idx_q - lag_q;
	assign v_go = (idx_q >= lag_q) && (q_pos < total_q);
	assign last_c = q_pos == (total_q - 1'b1);
	assign k_last = kcnt_q == TAP_W'(KERNEL_TAPS - 1);
	assign res_free = !res_valid_q || result.ready;
	assign emit = (state_q == ST_EMIT) && res_free;
	assign restart = cfg_wr || (emit && last_q);

	// column and row reach of the current tap
	assign w_s = HC_W'(w_c);
	assign hc = HC_W'(hcol_q) + HC_W'(HALF) - HC_W'(kcnt_q);
	assign h_in = !hc[HC_W-1] && (hc < w_s);
	assign h_s = VR_W'(h_c);
	assign vr = VR_W'(vrow_q) + VR_W'(HALF) - VR_W'(kcnt_q);
	assign v_in = !vr[VR_W-1] && (vr < h_s);

	// row-store slot of the bottom row of the vertical window
	assign slot_sum = (SLOT_W + 1)'(vslot_q) + (SLOT_W + 1)'(HALF);
	assign rslot_start = (slot_sum >= (SLOT_W + 1)'(SPAN)) ?
		SLOT_W'(slot_sum - (SLOT_W + 1)'(SPAN)) : SLOT_W'(slot_sum);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (idle_ok && (head.item.kind != WK_LOAD) && step) begin
					if (h_go) state_d = ST_HORIZ;
					else if (v_go) state_d = ST_VERT;
				end
			end
			ST_HORIZ: if (k_last) state_d = ST_HDRAIN;
			ST_HDRAIN: state_d = ST_HWRITE;
			ST_HWRITE: state_d = v_go_q ? ST_VERT : ST_IDLE;
			ST_VERT: if (k_last) state_d = ST_VDRAIN;
			ST_VDRAIN: if (!vv_s1 && !vv_s2) state_d = ST_EMIT;
			ST_EMIT: if (res_free) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		pop = idle_ok;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q <= DIM_W'(1024);
			frame_height_q <= DIM_W'(1024);
			total_q <= '0;
			lag_q <= '0;
			settle_q <= 1'b1;
			idx_q <= '0;
			hcol_q <= '0;
			hslot_q <= '0;
			vcol_q <= '0;
			vrow_q <= '0;
			vslot_q <= '0;
			rslot_q <= '0;
			kcnt_q <= '0;
			v_go_q <= 1'b0;
			last_q <= 1'b0;
			hv_s1 <= 1'b0;
			vv_s1 <= 1'b0;
			vv_s2 <= 1'b0;
			res_valid_q <= 1'b0;
			for (int i = 0; i < KERNEL_TAPS; i++) win_q[i] <= '0;
		end else begin
			total_q <= POS_W'(w_c) * POS_W'(h_c);
			lag_q <= POS_W'(w_c) * POS_W'(HALF) + POS_W'(HALF);
			// hold off the queue while the frame sums follow a register write
			settle_q <= cfg_wr;

			if (cfg_wr && (cfg.index == CFG_FRAME_WIDTH)) frame_width_q <= cfg.data;
			if (cfg_wr && (cfg.index == CFG_FRAME_HEIGHT)) frame_height_q <= cfg.data;

			if (idle_ok && (head.item.kind != WK_LOAD) && step) begin
				win_q[0] <= ((head.item.kind == WK_PIXEL) && in_frame) ? head.item.pix : '0;
				for (int i = 1; i < KERNEL_TAPS; i++) win_q[i] <= win_q[i-1];
				idx_q <= idx_q + 1'b1;
				v_go_q <= v_go;
				last_q <= last_c;
			end

			if (((state_q == ST_HORIZ) || (state_q == ST_VERT)) && !k_last)
				kcnt_q <= kcnt_q + 1'b1;
			else
				kcnt_q <= '0;

			if (state_q == ST_VERT)
				rslot_q <= (rslot_q == '0) ? SLOT_W'(SPAN - 1) : rslot_q - 1'b1;
			else
				rslot_q <= rslot_start;

			hv_s1 <= (state_q == ST_HORIZ) && h_in;
			vv_s1 <= (state_q == ST_VERT) && v_in;
			vv_s2 <= vv_s1;

			if (state_q == ST_HWRITE) begin
				if (hcol_q == COL_W'(w_c - 1'b1)) begin
					hcol_q <= '0;
					hslot_q <= (hslot_q == SLOT_W'(SPAN - 1)) ? '0 : hslot_q + 1'b1;
				end else begin
					hcol_q <= hcol_q + 1'b1;
				end
			end

			if (emit) begin
				res_valid_q <= 1'b1;
				if (vcol_q == COL_W'(w_c - 1'b1)) begin
					vcol_q <= '0;
					vrow_q <= vrow_q + 1'b1;
					vslot_q <= (vslot_q == SLOT_W'(SPAN - 1)) ? '0 : vslot_q + 1'b1;
				end else begin
					vcol_q <= vcol_q + 1'b1;
				end
			end else if (result.ready) begin
				res_valid_q <= 1'b0;
			end

			if (restart) begin
				idx_q <= '0;
				hcol_q <= '0;
				hslot_q <= '0;
				vcol_q <= '0;
				vrow_q <= '0;
				vslot_q <= '0;
				for (int i = 0; i < KERNEL_TAPS; i++) win_q[i] <= '0;
			end
		end
	end

	// kernel taps
	always_ff @(posedge clk) begin
		if (idle_ok && (head.item.kind == WK_LOAD)) begin
			case (head.item.ksel)
				KS_COS_H: tap_a_q[head.item.tap] <= head.item.coef;
				KS_COS_V: tap_b_q[head.item.tap] <= head.item.coef;
				KS_SIN_H: tap_c_q[head.item.tap] <= head.item.coef;
				KS_SIN_V: tap_d_q[head.item.tap] <= head.item.coef;
				default: ;
			endcase
		end
	end

	// horizontal pass: one tap per cycle
	always_ff @(posedge clk) begin
		hprod_a_s1 <= tap_a_q[kcnt_q] * $signed({1'b0, win_q[kcnt_q]});
		hprod_c_s1 <= tap_c_q[kcnt_q] * $signed({1'b0, win_q[kcnt_q]});
		if (state_q == ST_IDLE) begin
			hacc_a_q <= '0;
			hacc_c_q <= '0;
		end else if (hv_s1) begin
			hacc_a_q <= hacc_a_q + STORE_W'(hprod_a_s1);
			hacc_c_q <= hacc_c_q + STORE_W'(hprod_c_s1);
		end
	end

	// row stores
	always_ff @(posedge clk) begin
		if (state_q == ST_HWRITE) begin
			cos_mem[{hslot_q, hcol_q}] <= hacc_a_q;
			sin_mem[{hslot_q, hcol_q}] <= hacc_c_q;
		end
		cos_rd_s1 <= cos_mem[{rslot_q, vcol_q}];
		sin_rd_s1 <= sin_mem[{rslot_q, vcol_q}];
	end

	// vertical pass: read, multiply, accumulate
	always_ff @(posedge clk) begin
		tb_s1 <= tap_b_q[kcnt_q];
		td_s1 <= tap_d_q[kcnt_q];
		pb_s2 <= tb_s1 * cos_rd_s1;
		pd_s2 <= td_s1 * sin_rd_s1;
		if (state_q == ST_IDLE) vacc_q <= '0;
		else if (vv_s2) vacc_q <= vacc_q + OUT_W'(pb_s2) - OUT_W'(pd_s2);
		if (emit) begin
			res_data_q <= vacc_q;
			res_last_q <= last_q;
		end
	end

	assign result.valid = res_valid_q;
	assign result.filter_out = res_data_q;
	assign result.frame_end = res_last_q;

	assign stat.emit = emit;
	assign stat.emit_last = last_q;
	assign stat.at_start = idx_q == '0;

endmodule

### rtl/core/separable_gabor_convolution.sv
// Separable Gabor filter over a raster stream of 8-bit pixels. Each response is
// the horizontal pass with the cos kernel then the vertical pass, minus the same
// chain with the sin kernels, exact and scaled by 2^30. Responses lag their pixels
// by KERNEL_TAPS/2 rows plus KERNEL_TAPS/2 pixels; flush items after the frame
// push out the rest and the last response carries frame_end. The back end takes an
// item from the queue only while idle. A pixel or flush runs both passes, the
// horizontal pass only or the vertical pass only, and a vertical pass then waits for
// room at the output: one multiplier pair walks the horizontal taps, then one read
// port per row store and one multiplier pair walk the vertical taps. A four-entry
// queue in front lets items arrive while a response waits at the output. Load all
// four kernels before the first pixel; a frame register write restarts the frame.
module separable_gabor_convolution import gbr_pkg::*; (
	input logic clk,
	input logic arst_n,
	gbr_in_if.sink item,
	gbr_cfg_if.sink cfg,
	gbr_out_if.source result
);

	q_head_t head;
	logic pop;
	back_stat_t stat;

	gbr_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.item(item),
		.head(head),
		.pop(pop)
	);

	gbr_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.head(head),
		.pop(pop),
		.cfg(cfg),
		.result(result),
		.stat(stat)
	);

`ifndef SYNTHESIS
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head.valid) else $error("pop from empty queue");
	a_end_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		stat.emit && stat.emit_last |=> stat.at_start) else $error("frame did not restart");
	a_emit_sets_valid: assert property (@(posedge clk) disable iff (!arst_n)
		stat.emit |=> result.valid) else $error("response lost");
`endif

endmodule

### bench/tb.sv
module tb;
	import gbr_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		op_t op;
		ksel_t ks;
		logic [TAP_FIELD_W-1:0] ti;
		logic signed [COEF_W-1:0] coef;
		logic [PIX_W-1:0] pix;
	} gabor_item_t;

	typedef struct {
		logic signed [OUT_W-1:0] val;
		logic last;
	} gabor_resp_t;

	logic clk;
	logic arst_n;

	gbr_in_if in_bus();
	gbr_cfg_if cfg_bus();
	gbr_out_if out_bus();

	separable_gabor_convolution dut (
		.clk(clk),
		.arst_n(arst_n),
		.item(in_bus),
		.cfg(cfg_bus),
		.result(out_bus)
	);

	gabor_item_t pending_items[$];
	gabor_resp_t expected_resp[$];
	gabor_item_t cur_item;
	gabor_resp_t got_resp;
	int errors = 0;
	int src_idle = 0;
	int sink_stall = 0;
	bit drain_hold = 0;
	int random_items = 0;

	// shadow of the filter state
	int taps[4][KERNEL_TAPS];
	int window[SPAN];
	longint cos_rows[SPAN*MAX_WIDTH];
	longint sin_rows[SPAN*MAX_WIDTH];
	int in_pos, out_pos;
	int frame_w, frame_h;

	function automatic int clamp_dim(int v, int hi);
		if (v < 1) return 1;
		if (v > hi) return hi;
		return v;
	endfunction

	function automatic void restart_frame();
		in_pos = 0;
		out_pos = 0;
		foreach (window[i]) window[i] = 0;
	endfunction

	function automatic void predict_response(gabor_item_t it);
		int w, h, total, idx, m, row, col, q, y, x, r, c, slot, lag;
		longint sa, sc, acc;
		gabor_resp_t rs;
		if (it.op == OP_LOAD) begin
			if (it.ti < KERNEL_TAPS) taps[it.ks][it.ti] = it.coef;
			return;
		end
		if (it.op == OP_IGNORE) return;
		w = clamp_dim(frame_w, MAX_WIDTH);
		h = clamp_dim(frame_h, MAX_HEIGHT);
		total = w * h;
		if (it.op == OP_FLUSH && in_pos < total) return;
		for (int i = SPAN - 1; i > 0; i--) window[i] = window[i-1];
		window[0] = (it.op == OP_PIXEL && in_pos < total) ? int'(it.pix) : 0;
		idx = in_pos;
		in_pos++;
		if (idx >= HALF) begin
			m = idx - HALF;
			if (m < total) begin
				row = m / w;
				col = m % w;
				sa = 0;
				sc = 0;
				for (int t = -HALF; t <= HALF; t++) begin
					c = col - t;
					if (c >= 0 && c < w) begin
						sa += longint'(taps[KS_COS_H][t+HALF]) * window[HALF+t];
						sc += longint'(taps[KS_SIN_H][t+HALF]) * window[HALF+t];
					end
				end
				cos_rows[(row % SPAN) * MAX_WIDTH + col] = sa;
				sin_rows[(row % SPAN) * MAX_WIDTH + col] = sc;
			end
		end
		lag = HALF * w + HALF;
		if (idx >= lag) begin
			q = idx - lag;
			if (q < total) begin
				y = q / w;
				x = q % w;
				acc = 0;
				for (int t = -HALF; t <= HALF; t++) begin
					r = y - t;
					if (r >= 0 && r < h) begin
						slot = (r % SPAN) * MAX_WIDTH + x;
						acc += longint'(taps[KS_COS_V][t+HALF]) * cos_rows[slot];
						acc -= longint'(taps[KS_SIN_V][t+HALF]) * sin_rows[slot];
					end
				end
				rs.val = acc[OUT_W-1:0];
				rs.last = (q == total - 1);
				expected_resp.push_back(rs);
				out_pos = q + 1;
				if (rs.last) restart_frame();
			end
		end
	endfunction

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		arst_n = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1;
	end

	// input driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_bus.valid <= 0;
			in_bus.operation <= '0;
			in_bus.kernel_select <= '0;
			in_bus.tap_index <= '0;
			in_bus.coef_value <= '0;
			in_bus.pixel_value <= '0;
		end else begin
			if (in_bus.valid && in_bus.ready) predict_response(cur_item);
			if (!in_bus.valid || in_bus.ready) begin
				if (pending_items.size() > 0 && !(drain_hold && expected_resp.size() > 0)
						&& $urandom_range(99) >= src_idle) begin
					cur_item = pending_items.pop_front();
					in_bus.valid <= 1;
					in_bus.operation <= cur_item.op;
					in_bus.kernel_select <= cur_item.ks;
					in_bus.tap_index <= cur_item.ti;
					in_bus.coef_value <= cur_item.coef;
					in_bus.pixel_value <= cur_item.pix;
				end else begin
					in_bus.valid <= 0;
				end
			end
		end
	end

	// response monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_bus.ready <= 0;
		end else begin
			if (out_bus.valid && out_bus.ready) begin
				if (expected_resp.size() == 0) begin
					errors++;
					if (errors < 50)
						$display("%0t: unexpected response exp none got %0d/%0b", $time,
							out_bus.filter_out, out_bus.frame_end);
				end else begin
					got_resp = expected_resp.pop_front();
					if (got_resp.val !== out_bus.filter_out) begin
						errors++;
						if (errors < 50)
							$display("%0t: filter_out exp %0d got %0d", $time,
								got_resp.val, out_bus.filter_out);
					end
					if (got_resp.last !== out_bus.frame_end) begin
						errors++;
						if (errors < 50)
							$display("%0t: frame_end exp %0b got %0b", $time,
								got_resp.last, out_bus.frame_end);
					end
				end
			end
			out_bus.ready <= ($urandom_range(99) >= sink_stall);
		end
	end

	task automatic push_item(op_t op, int ks, int ti, int coef, int pix);
		gabor_item_t it;
		it.op = op;
		it.ks = ksel_t'(KSEL_W'(ks));
		it.ti = TAP_FIELD_W'(ti);
		it.coef = COEF_W'(coef);
		it.pix = PIX_W'(pix);
		pending_items.push_back(it);
	endtask

	task automatic push_noise();
		case ($urandom_range(3))
			0: push_item(OP_IGNORE, $urandom, $urandom, $urandom, $urandom);
			1: push_item(OP_LOAD, $urandom, $urandom_range(KERNEL_TAPS, 31), $urandom,
				$urandom);
			2: push_item(OP_FLUSH, $urandom, $urandom, $urandom, $urandom);
			default: push_item(OP_LOAD, $urandom, $urandom_range(KERNEL_TAPS - 1),
				$urandom, $urandom);
		endcase
	endtask

	// wait for the queue and the back end to run dry as well
	task automatic settle();
		while (pending_items.size() > 0 || in_bus.valid || expected_resp.size() > 0)
			@(posedge clk);
		repeat ((QDEPTH + 2) * (2 * KERNEL_TAPS + 8)) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int value);
		@(posedge clk);
		cfg_bus.valid <= 1;
		cfg_bus.index <= idx;
		cfg_bus.data <= DIM_W'(value);
		do @(posedge clk); while (!cfg_bus.ready);
		cfg_bus.valid <= 0;
		if (idx == CFG_FRAME_WIDTH) begin
			frame_w = value & 'h7ff;
			restart_frame();
		end else if (idx == CFG_FRAME_HEIGHT) begin
			frame_h = value & 'h7ff;
			restart_frame();
		end
	endtask

	// pixels of a whole frame with optional noise items, then enough flush or pixel items to drain it
	task automatic push_frame(int noise_pct, bit count_it);
		int w, h, n;
		w = clamp_dim(frame_w, MAX_WIDTH);
		h = clamp_dim(frame_h, MAX_HEIGHT);
		n = 0;
		while (n < w * h) begin
			if ($urandom_range(99) < noise_pct) begin
				push_noise();
			end else begin
				push_item(OP_PIXEL, $urandom, $urandom, $urandom, $urandom);
				n++;
			end
			if (count_it) random_items++;
		end
		for (int i = 0; i < HALF * w + HALF; i++) begin
			if ($urandom_range(3) == 0)
				push_item(OP_PIXEL, $urandom, $urandom, $urandom, $urandom);
			else
				push_item(OP_FLUSH, $urandom, $urandom, $urandom, $urandom);
			if (count_it) random_items++;
		end
	endtask

	initial begin
		int mode;
		cfg_bus.valid = 0;
		cfg_bus.index = '0;
		cfg_bus.data = '0;
		foreach (taps[k, t]) taps[k][t] = 0;
		frame_w = 1024;
		frame_h = 1024;
		restart_frame();
		@(posedge arst_n);
		repeat (2) @(posedge clk);

		write_reg(CFG_FRAME_WIDTH, 3);
		write_reg(CFG_FRAME_HEIGHT, 2);
		for (int k = 0; k < 4; k++)
			for (int t = 0; t < KERNEL_TAPS; t++)
				push_item(OP_LOAD, k, t, (t == 0) ? -32768 : (t == HALF) ? 32767 :
					$urandom, $urandom);
		push_item(OP_LOAD, KS_COS_H, KERNEL_TAPS, 0, 0);
		push_item(OP_LOAD, KS_SIN_V, 31, -1, 255);
		push_item(OP_IGNORE, 3, 31, -1, 255);
		push_item(OP_FLUSH, 0, 0, 0, 0);
		push_item(OP_PIXEL, 0, 0, 0, 255);
		push_item(OP_PIXEL, 0, 0, 0, 0);
		push_item(OP_PIXEL, 0, 0, 0, 255);
		push_item(OP_PIXEL, 0, 0, 0, 255);
		push_item(OP_PIXEL, 0, 0, 0, 0);
		push_item(OP_PIXEL, 0, 0, 0, 128);
		for (int i = 0; i < HALF * 3 + HALF; i++)
			push_item((i % 2) ? OP_FLUSH : OP_PIXEL, 0, 0, 0, 255);
		settle();

		// index without a register, then a restart in the middle of a frame
		write_reg(2'd2, $urandom);
		write_reg(2'd3, $urandom);
		write_reg(CFG_FRAME_WIDTH, 4);
		write_reg(CFG_FRAME_HEIGHT, 4);
		repeat (5) push_item(OP_PIXEL, 0, 0, 0, $urandom);
		settle();
		write_reg(CFG_FRAME_WIDTH, 4);
		push_frame(0, 0);
		settle();

		// clamped extremes, partial frames cut short by the next register write
		write_reg(CFG_FRAME_WIDTH, 0);
		write_reg(CFG_FRAME_HEIGHT, 2047);
		repeat (40) push_item(OP_PIXEL, 0, 0, 0, $urandom);
		settle();
		write_reg(CFG_FRAME_WIDTH, 2047);
		write_reg(CFG_FRAME_HEIGHT, 0);
		repeat (20) push_item(OP_PIXEL, 0, 0, 0, $urandom);
		settle();
		write_reg(CFG_FRAME_WIDTH, 1);
		write_reg(CFG_FRAME_HEIGHT, 1);
		push_frame(0, 0);
		settle();

		mode = 0;
		while (random_items < 1300) begin
			case (mode % 4)
				0: begin src_idle = 0; sink_stall = 0; end
				1: begin src_idle = 59; sink_stall = 0; end
				2: begin src_idle = 0; sink_stall = 59; end
				default: begin src_idle = 9; sink_stall = 9; end
			endcase
			drain_hold = (mode == 5);
			write_reg(CFG_FRAME_WIDTH, $urandom_range(1, 9));
			write_reg(CFG_FRAME_HEIGHT, $urandom_range(1, 9));
			if ($urandom_range(2) == 0)
				repeat ($urandom_range(1, 8))
					push_item(OP_LOAD, $urandom, $urandom_range(KERNEL_TAPS - 1),
						$urandom, $urandom);
			push_frame(10, 1);
			settle();
			mode++;
		end
		drain_hold = 0;
		settle();
		repeat (100) @(posedge clk);
		if (errors == 0)
			$display("tb: done, clean");
		else
			$display("tb: done, errors");
		$finish;
	end

	initial begin
		#30ms;
		$display("tb: done, errors");
		$finish;
	end

endmodule

### separable_gabor_convolution.f
rtl/core/gbr_pkg.sv
rtl/core/gbr_ifs.sv
rtl/core/gbr_front.sv
rtl/core/gbr_back.sv
rtl/core/separable_gabor_convolution.sv
bench/tb.sv
